// File: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int MAX_DIGITS     = 10;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [2:0] FUNC_PUT     = 3'd0;
  localparam logic [2:0] FUNC_BACK    = 3'd1;
  localparam logic [2:0] FUNC_ENTER   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR   = 3'd3;
  localparam logic [2:0] FUNC_DECIMAL = 3'd4;

  localparam logic [1:0] KIND_CELL = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_ZERO     = 8'd48;
  localparam logic [7:0] DEFAULT_COLOR = 8'h07;

  // q = (n * RECIP_TEN) >> RECIP_SHIFT is n / 10 for any 32-bit n
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         in_char;
    logic signed [31:0] number;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [10:0] cell_index;
    logic [7:0]  out_char;
    logic [7:0]  attribute;
    logic [4:0]  row_now;
    logic [6:0]  col_now;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_BACK,
    OP_ENTER,
    OP_CLEAR
  } op_code_t;

  typedef struct packed {
    op_code_t   op;
    logic [7:0] ch;
    logic       last;
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_EMIT
  } front_state_t;

endpackage

// File: rtl/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Accepts commands, classifies them and breaks decimals into digit items.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; #(
  parameter int MaxDigits = MAX_DIGITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  input  logic q_full,
  output logic push,
  output op_t  push_item
);

  localparam int DCW = $clog2(MaxDigits + 1);
  localparam int DIW = $clog2(MaxDigits);

  front_state_t state, state_next;
  logic [30:0]    num;
  logic [62:0]    prod;
  logic [3:0]     digit_store [MaxDigits];
  logic [DCW-1:0] digit_count;
  logic [DCW-1:0] cnt_less;
  logic [27:0]    quot;
  logic [30:0]    rem_full;
  logic [3:0]     digit_rd;
  logic           accept;
  logic           div_done;

  assign accept   = (state == F_IDLE) && cmd_valid && !q_full;
  assign quot     = prod[62:RECIP_SHIFT];
  assign rem_full = num - (31'(quot) << 3) - (31'(quot) << 1);
  assign cnt_less = digit_count - DCW'(1);
  assign digit_rd = digit_store[cnt_less[DIW-1:0]];
  assign div_done = (quot == '0) || (digit_count + DCW'(1) == DCW'(MaxDigits));

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept && cmd.func == FUNC_DECIMAL && !cmd.number[31] && cmd.number != '0) begin
          state_next = F_MUL;
        end
      end
      F_MUL:  state_next = F_DIV;
      F_DIV:  state_next = div_done ? F_EMIT : F_MUL;
      F_EMIT: begin
        if (!q_full && digit_count == DCW'(1)) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = (state != F_IDLE) || q_full;
    push      = 1'b0;
    push_item = '{op: OP_PUT, ch: cmd.in_char, last: 1'b1};
    case (state)
      F_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FUNC_PUT:   push = 1'b1;
            FUNC_BACK: begin
              push         = 1'b1;
              push_item.op = OP_BACK;
            end
            FUNC_ENTER: begin
              push         = 1'b1;
              push_item.op = OP_ENTER;
            end
            FUNC_CLEAR: begin
              push         = 1'b1;
              push_item.op = OP_CLEAR;
            end
            FUNC_DECIMAL: begin
              if (cmd.number == '0) begin
                push         = 1'b1;
                push_item.ch = CHAR_ZERO;
              end
            end
            default: push = 1'b0;
          endcase
        end
      end
      F_EMIT: begin
        push           = !q_full;
        push_item.ch   = CHAR_ZERO + {4'd0, digit_rd};
        push_item.last = (digit_count == DCW'(1));
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      digit_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        digit_count <= '0;
      end else if (state == F_DIV) begin
        digit_count <= digit_count + DCW'(1);
      end else if (state == F_EMIT && !q_full) begin
        digit_count <= cnt_less;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      num <= cmd.number[30:0];
    end else if (state == F_DIV) begin
      num <= 31'(quot);
    end
    if (state == F_MUL) begin
      prod <= num * RECIP_TEN;
    end
    if (state == F_DIV) begin
      digit_store[digit_count[DIW-1:0]] <= rem_full[3:0];
    end
  end

endmodule

// File: rtl/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue
// Small FIFO of cursor operations between the front and back parts.
// ----------------------------------------------------------------------------
module tccw_queue import tccw_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  queue_ctl_t ctl,
  input  op_t        wr_item,
  output op_t        rd_item,
  output logic       not_empty,
  output logic       full
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  op_t           slots [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign not_empty = (fill != '0);
  assign full      = (fill == CW'(Depth));
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= (wr_ptr == PW'(Depth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (ctl.pop) begin
        rd_ptr <= (rd_ptr == PW'(Depth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (ctl.push && !ctl.pop) begin
        fill <= fill + CW'(1);
      end else if (!ctl.push && ctl.pop) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: rtl/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Moves the cursor per operation and registers the frame buffer request.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; #(
  parameter int Cols = SCREEN_COLUMNS,
  parameter int Rows = SCREEN_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_color,
  input  logic       op_valid,
  input  op_t        op_item,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res
);

  localparam int RW    = $clog2(Rows);
  localparam int CW    = $clog2(Cols);
  localparam int CELLW = $clog2(Rows * Cols);
  localparam int CXW   = (CELLW > 11) ? CELLW : 11;
  localparam int RXW   = (RW > 5) ? RW : 5;
  localparam int KXW   = (CW > 7) ? CW : 7;

  logic [RW-1:0]  row, row_next, row_inc, cell_row;
  logic [CW-1:0]  col, col_next, cell_col;
  logic [CXW-1:0] cell_full;
  logic [RXW-1:0] row_ext;
  logic [KXW-1:0] col_ext;
  logic           emit;
  res_t           res_next;

  assign pop       = op_valid && (!res_valid || !res_stall);
  assign row_inc   = (row == RW'(Rows - 1)) ? '0 : row + RW'(1);
  assign cell_full = CXW'(cell_row) * CXW'(Cols) + CXW'(cell_col);
  assign row_ext   = RXW'(row_next);
  assign col_ext   = KXW'(col_next);

  always_comb begin
    row_next   = row;
    col_next   = col;
    cell_row   = row;
    cell_col   = col;
    emit       = 1'b1;
    res_next   = '0;
    res_next.write_kind = KIND_CELL;
    res_next.out_char   = op_item.ch;
    res_next.attribute  = text_color;
    case (op_item.op)
      OP_PUT: begin
        if (op_item.ch == CHAR_NEWLINE) begin
          row_next = row_inc;
          col_next = '0;
          cell_row = row_inc;
          cell_col = '0;
          res_next.write_kind = KIND_MOVE;
          res_next.out_char   = '0;
          res_next.attribute  = '0;
        end else if (col == CW'(Cols - 1)) begin
          row_next = row_inc;
          col_next = '0;
        end else begin
          col_next = col + CW'(1);
        end
      end
      OP_BACK: begin
        if (row == '0 && col == '0) begin
          emit = 1'b0;
        end else if (col == '0) begin
          row_next = row - RW'(1);
          col_next = CW'(Cols - 1);
        end else begin
          col_next = col - CW'(1);
        end
        cell_row = row_next;
        cell_col = col_next;
        res_next.out_char = CHAR_SPACE;
      end
      OP_ENTER: begin
        row_next = row_inc;
        col_next = '0;
        cell_row = row_inc;
        cell_col = '0;
        res_next.write_kind = KIND_MOVE;
        res_next.out_char   = '0;
        res_next.attribute  = '0;
      end
      OP_CLEAR: begin
        row_next = '0;
        col_next = '0;
        cell_row = '0;
        cell_col = '0;
        res_next.write_kind = KIND_FILL;
        res_next.out_char   = CHAR_SPACE;
      end
      default: emit = 1'b0;
    endcase
    res_next.cell_index = cell_full[10:0];
    res_next.row_now    = row_ext[4:0];
    res_next.col_now    = col_ext[6:0];
    res_next.last       = op_item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        row       <= row_next;
        col       <= col_next;
        res_valid <= emit;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Text console writer: cursor tracking and frame buffer cell requests.
// ----------------------------------------------------------------------------
// Put character, backspace, enter and clear each pass through the front, the
// queue and the back, and such commands flow at one per cycle while the queue
// has room and the result is not stalled. Write decimal holds the command
// port while the front loops per digit through a multiply by the reciprocal
// of ten and a subtract for the remainder, then hands the digits to the queue
// one by one. Results leave through a registered output stage.
module text_console_cursor_writer import tccw_pkg::*; #(
  parameter int ScreenColumns = SCREEN_COLUMNS,
  parameter int ScreenRows    = SCREEN_ROWS,
  parameter int MaxDigits     = MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] text_color;
  logic       q_full;
  logic       q_not_empty;
  logic       push;
  logic       pop;
  op_t        push_item;
  op_t        pop_item;
  queue_ctl_t qctl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color} : '0;
  assign qctl   = '{push: push, pop: pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= DEFAULT_COLOR;
    end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_COLOR) begin
      text_color <= pwdata[7:0];
    end
  end

  tccw_front #(
    .MaxDigits(MaxDigits)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item)
  );

  tccw_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (qctl),
    .wr_item  (push_item),
    .rd_item  (pop_item),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  tccw_back #(
    .Cols(ScreenColumns),
    .Rows(ScreenRows)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .text_color(text_color),
    .op_valid  (q_not_empty),
    .op_item   (pop_item),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.write_kind == KIND_CELL || res.write_kind == KIND_FILL ||
                   res.write_kind == KIND_MOVE))
    else $error("result kind out of range");

  a_fill_homes: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.write_kind == KIND_FILL |->
      res.row_now == '0 && res.col_now == '0 && res.cell_index == '0)
    else $error("fill did not home the cursor");

  a_move_col0: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.write_kind == KIND_MOVE |-> res.col_now == '0 && res.out_char == '0)
    else $error("cursor move not at column zero");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push || pop)
    else $error("push into full queue");

endmodule

// File: tb/sv/tb_text_console_cursor_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_writer
// Self-checking bench for the text console cursor writer.
// A short directed table covers the origin backspace, newline, enter, line
// wrap, clear, zero, negative and ten-digit decimals and the unused command
// codes. Random phases follow under several text colors and under sender
// idling, receiver stalling and one long receiver hold-off. Every accepted
// result is compared field by field with a typed row or the cursor predictor.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_writer;
  import tccw_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 80;

  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;

  localparam logic [2:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};

  localparam logic [1:0] ROW_PREDICT = 2'd0;
  localparam logic [1:0] ROW_NONE    = 2'd1;
  localparam logic [1:0] ROW_ONE     = 2'd2;

  typedef struct packed {
    cmd_t       c;
    logic [1:0] mode;
    res_t       r;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  text_console_cursor_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  text_color_now;
  res_t        step_out[$];
  res_t        writes_due[$];
  dir_row_t    directed_rows[$];

  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req_count;
  int hold_seen;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 50) $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  function automatic res_t cell_req(input logic [1:0] kind, input int unsigned cell_no,
                                    input logic [7:0] ch, input logic [7:0] attr);
    res_t r;
    r.write_kind = kind;
    r.cell_index = cell_no[10:0];
    r.out_char   = ch;
    r.attribute  = attr;
    r.row_now    = cur_row[4:0];
    r.col_now    = cur_col[6:0];
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic void next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_ROWS) cur_row = 0;
  endfunction

  function automatic void put_glyph(input logic [7:0] c);
    int unsigned cell_no;
    if (c == CHAR_NEWLINE) begin
      next_row();
      step_out.push_back(cell_req(KIND_MOVE, cur_row * SCREEN_COLUMNS + cur_col, 8'h00, 8'h00));
    end else begin
      cell_no = cur_row * SCREEN_COLUMNS + cur_col;
      cur_col++;
      if (cur_col >= SCREEN_COLUMNS) next_row();
      step_out.push_back(cell_req(KIND_CELL, cell_no, c, text_color_now));
    end
  endfunction

  function automatic void console_step(input cmd_t c);
    logic [31:0] n;
    logic [3:0]  digs [MAX_DIGITS];
    int          nd;
    step_out.delete();
    case (c.func)
      FUNC_PUT: put_glyph(c.in_char);
      FUNC_BACK: begin
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = SCREEN_COLUMNS - 1;
          end else begin
            cur_col--;
          end
          step_out.push_back(cell_req(KIND_CELL, cur_row * SCREEN_COLUMNS + cur_col,
                                      CHAR_SPACE, text_color_now));
        end
      end
      FUNC_ENTER: begin
        next_row();
        step_out.push_back(cell_req(KIND_MOVE, cur_row * SCREEN_COLUMNS + cur_col, 8'h00, 8'h00));
      end
      FUNC_CLEAR: begin
        cur_row = 0;
        cur_col = 0;
        step_out.push_back(cell_req(KIND_FILL, 0, CHAR_SPACE, text_color_now));
      end
      FUNC_DECIMAL: begin
        n = c.number;
        if (!n[31]) begin
          if (n == 0) begin
            put_glyph(CHAR_ZERO);
          end else begin
            nd = 0;
            while (n > 0 && nd < MAX_DIGITS) begin
              digs[nd] = 4'(n % 10);
              nd++;
              n = n / 10;
            end
            for (int j = nd - 1; j >= 0; j--) put_glyph(CHAR_ZERO + digs[j]);
          end
        end
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  task automatic push_cmd(input cmd_t c, input logic [1:0] mode, input res_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    console_step(c);
    case (mode)
      ROW_ONE:  writes_due.push_back(typed);
      ROW_NONE: ;
      default: begin
        foreach (step_out[i]) writes_due.push_back(step_out[i]);
      end
    endcase
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_text_color(input logic [7:0] color);
    logic [31:0] rd;
    reg_access(1'b1, ADDR_TEXT_COLOR, {24'h0, color}, rd);
    text_color_now = color;
    @(posedge clk);
    reg_access(1'b0, ADDR_TEXT_COLOR, 32'h0, rd);
    if (rd[7:0] !== color) report_mismatch("text_color readback", rd[7:0], color);
  endtask

  task automatic drain();
    while (writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned pick;
    int unsigned sel;
    c.in_char = 8'($urandom);
    c.number  = $urandom;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 45) begin
      c.func = FUNC_PUT;
      if (sel < 10) c.in_char = CHAR_NEWLINE;
    end else if (pick < 57) begin
      c.func = FUNC_BACK;
    end else if (pick < 69) begin
      c.func = FUNC_ENTER;
    end else if (pick < 72) begin
      c.func = FUNC_CLEAR;
    end else if (pick < 95) begin
      c.func = FUNC_DECIMAL;
      if (sel < 55)      c.number = $urandom_range(999);
      else if (sel < 70) c.number = $urandom_range(99999);
      else if (sel < 85) c.number = $urandom;
      else if (sel < 90) c.number = 32'sd0;
      else if (sel < 95) c.number = 32'sh7FFF_FFFF;
      else               c.number = {1'b0, 31'($urandom)};
    end else begin
      c.func = FUNC_SPARE_A + 3'($urandom_range(2));
    end
    return c;
  endfunction

  function automatic void add_row(input cmd_t c, input logic [1:0] mode, input res_t r);
    dir_row_t d;
    d.c    = c;
    d.mode = mode;
    d.r    = r;
    directed_rows.push_back(d);
  endfunction

  always @(posedge clk) begin : res_sink
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req_count) begin
      hold_seen = hold_req_count;
      res_stall <= 1'b1;
      hold_left <= LONG_HOLD;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : res_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (writes_due.size() == 0) begin
        report_mismatch("result with nothing pending", res, 0);
      end else begin
        want = writes_due.pop_front();
        if (res.write_kind !== want.write_kind)
          report_mismatch("write_kind", res.write_kind, want.write_kind);
        if (res.cell_index !== want.cell_index)
          report_mismatch("cell_index", res.cell_index, want.cell_index);
        if (res.out_char !== want.out_char)
          report_mismatch("out_char", res.out_char, want.out_char);
        if (res.attribute !== want.attribute)
          report_mismatch("attribute", res.attribute, want.attribute);
        if (res.row_now !== want.row_now)
          report_mismatch("row_now", res.row_now, want.row_now);
        if (res.col_now !== want.col_now)
          report_mismatch("col_now", res.col_now, want.col_now);
        if (res.last !== want.last)
          report_mismatch("last", res.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    res_t        blank;
    rst            = 1'b1;
    cmd_valid      = 1'b0;
    cmd            = '0;
    res_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_count = 0;
    hold_seen      = 0;
    hold_left      = 0;
    cur_row        = 0;
    cur_col        = 0;
    text_color_now = DEFAULT_COLOR;
    blank          = '0;

    add_row({FUNC_BACK,    8'h00, 32'h0000_0000}, ROW_NONE, blank);
    add_row({FUNC_SPARE_A, 8'hFF, 32'h7FFF_FFFF}, ROW_NONE, blank);
    add_row({FUNC_SPARE_C, 8'h00, 32'h0000_0000}, ROW_NONE, blank);
    add_row({FUNC_DECIMAL, 8'h00, 32'h8000_0000}, ROW_NONE, blank);
    add_row({FUNC_PUT,     8'h41, 32'h0000_0000}, ROW_ONE,
            {KIND_CELL, 11'd0, 8'h41, DEFAULT_COLOR, 5'd0, 7'd1, 1'b1});
    add_row({FUNC_BACK,    8'h00, 32'h0000_0000}, ROW_ONE,
            {KIND_CELL, 11'd0, CHAR_SPACE, DEFAULT_COLOR, 5'd0, 7'd0, 1'b1});
    add_row({FUNC_DECIMAL, 8'hFF, 32'h0000_0000}, ROW_ONE,
            {KIND_CELL, 11'd0, CHAR_ZERO, DEFAULT_COLOR, 5'd0, 7'd1, 1'b1});
    add_row({FUNC_PUT,     CHAR_NEWLINE, 32'hFFFF_FFFF}, ROW_ONE,
            {KIND_MOVE, 11'd80, 8'h00, 8'h00, 5'd1, 7'd0, 1'b1});
    add_row({FUNC_ENTER,   8'h00, 32'h0000_0000}, ROW_ONE,
            {KIND_MOVE, 11'd160, 8'h00, 8'h00, 5'd2, 7'd0, 1'b1});
    add_row({FUNC_BACK,    8'hFF, 32'hFFFF_FFFF}, ROW_ONE,
            {KIND_CELL, 11'd159, CHAR_SPACE, DEFAULT_COLOR, 5'd1, 7'd79, 1'b1});
    add_row({FUNC_PUT,     8'hFF, 32'h0000_0000}, ROW_ONE,
            {KIND_CELL, 11'd159, 8'hFF, DEFAULT_COLOR, 5'd2, 7'd0, 1'b1});
    add_row({FUNC_PUT,     8'h00, 32'h0000_0000}, ROW_PREDICT, blank);
    add_row({FUNC_DECIMAL, 8'h00, 32'h7FFF_FFFF}, ROW_PREDICT, blank);
    add_row({FUNC_DECIMAL, 8'h00, 32'h0000_0001}, ROW_PREDICT, blank);
    add_row({FUNC_DECIMAL, 8'h00, 32'd1000000000}, ROW_PREDICT, blank);
    add_row({FUNC_DECIMAL, 8'h00, 32'hFFFF_FFFF}, ROW_NONE, blank);
    add_row({FUNC_SPARE_B, 8'h55, 32'h5555_5555}, ROW_NONE, blank);
    add_row({FUNC_ENTER,   8'hAA, 32'hAAAA_AAAA}, ROW_PREDICT, blank);
    add_row({FUNC_BACK,    8'h00, 32'h0000_0000}, ROW_PREDICT, blank);
    add_row({FUNC_CLEAR,   8'h00, 32'h0000_0000}, ROW_ONE,
            {KIND_FILL, 11'd0, CHAR_SPACE, DEFAULT_COLOR, 5'd0, 7'd0, 1'b1});
    add_row({FUNC_DECIMAL, 8'h00, 32'd9}, ROW_PREDICT, blank);
    add_row({FUNC_DECIMAL, 8'h00, 32'd10}, ROW_PREDICT, blank);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_access(1'b0, ADDR_TEXT_COLOR, 32'h0, rd);
    if (rd[7:0] !== DEFAULT_COLOR) report_mismatch("text_color after reset", rd[7:0], DEFAULT_COLOR);

    foreach (directed_rows[i]) push_cmd(directed_rows[i].c, directed_rows[i].mode,
                                        directed_rows[i].r);
    cmd_valid <= 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0:       set_text_color(8'h00);
        1:       set_text_color(8'hFF);
        default: set_text_color(8'($urandom));
      endcase
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        3:       begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req_count++; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) push_cmd(rand_cmd(), ROW_PREDICT, blank);
      cmd_valid <= 1'b0;
    end

    drain();
    if (mismatches == 0 && writes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
